// ----- sv/dps_pkg.sv -----
// data poll scheduler package: item, result and configuration types,
// event and register codes, fixed counts
// no dependencies
package dps_pkg;

  localparam int unsigned PeriodW = 31;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [3:0] QUICK_POLLS_AFTER_TIMEOUT = 4'd5;
  localparam logic [7:0] MAX_FAST_POLLS            = 8'd15;
  localparam logic [7:0] DEFAULT_FAST_POLLS        = 8'd8;
  localparam logic [7:0] MAX_FAST_POLL_USERS       = 8'd63;

  typedef enum logic [3:0] {
    MODE_TICK       = 4'd0,
    MODE_POLL_DONE  = 4'd1,
    MODE_TIMEOUT    = 4'd2,
    MODE_RX_FRAME   = 4'd3,
    MODE_FAST_START = 4'd4,
    MODE_FAST_STOP  = 4'd5,
    MODE_START      = 4'd6,
    MODE_STOP       = 4'd7,
    MODE_SEND       = 4'd8,
    MODE_RECALC     = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    TX_OK      = 2'd0,
    TX_CCA     = 2'd1,
    TX_OTHER   = 2'd2,
    TX_UNKNOWN = 2'd3
  } tx_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_PERIOD  = 3'd0,
    CFG_EXTERNAL_PERIOD = 3'd1,
    CFG_ATTACH_MODE     = 3'd2,
    CFG_ATTACH_PERIOD   = 3'd3,
    CFG_RETX_PERIOD     = 3'd4,
    CFG_FAST_PERIOD     = 3'd5,
    CFG_MIN_PERIOD      = 3'd6,
    CFG_MAX_RETX        = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] mode;
    logic       parent_valid;
    logic [1:0] tx_status;
    logic       frame_pending;
    logic [7:0] fast_poll_count;
  } item_t;

  typedef struct packed {
    logic               send_poll;
    logic [PeriodW-1:0] poll_period;
    logic               detach;
    logic               status;
  } res_t;

  typedef struct packed {
    logic [PeriodW-1:0] default_period;
    logic [PeriodW-1:0] external_period;
    logic               attach_mode;
    logic [15:0]        attach_period;
    logic [15:0]        retx_period;
    logic [15:0]        fast_period;
    logic [15:0]        min_period;
    logic [3:0]         max_retx_attempts;
  } cfg_t;

endpackage

// ----- sv/dps_if.sv -----
// data poll scheduler channel interfaces: item in, result out, config write
// uses dps_pkg for field widths
interface dps_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic       parent_valid;
  logic [1:0] tx_status;
  logic       frame_pending;
  logic [7:0] fast_poll_count;

  modport source (output valid, mode, parent_valid, tx_status, frame_pending,
                  fast_poll_count, input ready);
  modport sink (input valid, mode, parent_valid, tx_status, frame_pending,
                fast_poll_count, output ready);
endinterface

interface dps_res_if;
  logic                        valid;
  logic                        ready;
  logic                        send_poll;
  logic [dps_pkg::PeriodW-1:0] poll_period;
  logic                        detach;
  logic                        status;

  modport source (output valid, send_poll, poll_period, detach, status, input ready);
  modport sink (input valid, send_poll, poll_period, detach, status, output ready);
endinterface

interface dps_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dps_pkg::CfgIdxW-1:0] index;
  logic [dps_pkg::PeriodW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/dps_ctrl.sv -----
// data poll scheduler state and next-state logic: config registers,
// counters, poll timer, period selection and result word
// depends on dps_pkg
module dps_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_acc_i,
  input  dps_pkg::item_t                 item_i,
  input  logic                           cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dps_pkg::PeriodW-1:0]    cfg_data_i,
  output dps_pkg::res_t                  res_o
);

  localparam int unsigned PW = dps_pkg::PeriodW;
  localparam int unsigned TW = dps_pkg::TimeW;

  dps_pkg::cfg_t   cfg_q, cfg_d;
  logic            en_q, en_d;
  logic            retx_q, retx_d;
  logic            run_q, run_d;
  logic [3:0]      fc_q, fc_d;
  logic [3:0]      to_q, to_d;
  logic [7:0]      fr_q, fr_d;
  logic [7:0]      fu_q, fu_d;
  logic [PW-1:0]   per_q, per_d;
  logic [TW-1:0]   ts_q, ts_d;
  logic [TW-1:0]   ct_q, ct_d;
  logic [TW-1:0]   dl_q, dl_d;

  function automatic logic [PW-1:0] calc_period(dps_pkg::cfg_t c, logic retx,
                                                 logic fast);
    logic [PW-1:0] p;
    p = c.default_period;
    if (c.attach_mode && {{(PW-16){1'b0}}, c.attach_period} < p) begin
      p = {{(PW-16){1'b0}}, c.attach_period};
    end
    if (retx && {{(PW-16){1'b0}}, c.retx_period} < p) begin
      p = {{(PW-16){1'b0}}, c.retx_period};
    end
    if (fast && {{(PW-16){1'b0}}, c.fast_period} < p) begin
      p = {{(PW-16){1'b0}}, c.fast_period};
    end
    if (c.external_period != '0 && c.external_period < p) begin
      p = c.external_period;
    end
    if (p == '0) begin
      p = {{(PW-16){1'b0}}, c.min_period};
    end
    return p;
  endfunction

  always_comb begin
    logic          poll;
    logic          halt;
    logic          resched;
    logic          restart;
    logic [7:0]    cnt;
    logic [TW-1:0] tick_diff;
    logic [TW-1:0] sa;
    logic [TW-1:0] sb;
    logic [TW-1:0] sdiff;
    cfg_d   = cfg_q;
    en_d    = en_q;
    retx_d  = retx_q;
    run_d   = run_q;
    fc_d    = fc_q;
    to_d    = to_q;
    fr_d    = fr_q;
    fu_d    = fu_q;
    per_d   = per_q;
    ts_d    = ts_q;
    ct_d    = ct_q;
    dl_d    = dl_q;
    res_o   = '0;
    poll    = 1'b0;
    halt    = 1'b0;
    resched = 1'b0;
    restart = 1'b0;
    cnt     = item_i.fast_poll_count;
    tick_diff = ct_q + TW'(1) - dl_q;
    sa      = '0;
    sb      = '0;
    sdiff   = '0;

    if (cfg_we_i) begin
      case (dps_pkg::cfg_idx_e'(cfg_idx_i))
        dps_pkg::CFG_DEFAULT_PERIOD: cfg_d.default_period = cfg_data_i;
        dps_pkg::CFG_EXTERNAL_PERIOD: begin
          if (cfg_data_i != cfg_q.external_period) begin
            cfg_d.external_period = cfg_data_i;
            resched = en_q;
          end
        end
        dps_pkg::CFG_ATTACH_MODE: begin
          if (cfg_data_i[0] != cfg_q.attach_mode) begin
            cfg_d.attach_mode = cfg_data_i[0];
            resched = en_q;
          end
        end
        dps_pkg::CFG_ATTACH_PERIOD: cfg_d.attach_period = cfg_data_i[15:0];
        dps_pkg::CFG_RETX_PERIOD: cfg_d.retx_period = cfg_data_i[15:0];
        dps_pkg::CFG_FAST_PERIOD: cfg_d.fast_period = cfg_data_i[15:0];
        dps_pkg::CFG_MIN_PERIOD: cfg_d.min_period = cfg_data_i[15:0];
        dps_pkg::CFG_MAX_RETX: cfg_d.max_retx_attempts = cfg_data_i[3:0];
        default: ;
      endcase
    end else if (in_acc_i) begin
      case (dps_pkg::mode_e'(item_i.mode))
        dps_pkg::MODE_TICK: begin
          ct_d = ct_q + TW'(1);
          // wrapping compare: fired once now - deadline is not negative
          if (run_q && !tick_diff[TW-1]) begin
            run_d = 1'b0;
            poll  = 1'b1;
          end
        end
        dps_pkg::MODE_POLL_DONE: begin
          if (en_q) begin
            if (!item_i.parent_valid) begin
              halt         = 1'b1;
              res_o.detach = 1'b1;
            end else if (item_i.tx_status == dps_pkg::TX_OK) begin
              if (fr_q != '0) begin
                fr_d = fr_q - 8'd1;
                if (fr_q == 8'd1) begin
                  resched = 1'b1;
                  fu_d    = '0;
                end
              end
              if (retx_q) begin
                retx_d  = 1'b0;
                fc_d    = '0;
                resched = 1'b1;
              end
            end else if (item_i.tx_status == dps_pkg::TX_CCA) begin
              retx_d  = 1'b1;
              resched = 1'b1;
            end else begin
              fc_d = fc_q + 4'd1;
              if (fc_d < cfg_q.max_retx_attempts) begin
                if (!retx_q) begin
                  retx_d  = 1'b1;
                  resched = 1'b1;
                end
              end else begin
                retx_d  = 1'b0;
                fc_d    = '0;
                resched = 1'b1;
              end
            end
          end
        end
        dps_pkg::MODE_TIMEOUT: begin
          if (en_q) begin
            to_d = to_q + 4'd1;
            if (to_d < dps_pkg::QUICK_POLLS_AFTER_TIMEOUT) begin
              poll = 1'b1;
            end else begin
              to_d = '0;
            end
          end
        end
        dps_pkg::MODE_RX_FRAME: begin
          if (en_q) begin
            to_d = '0;
            poll = item_i.frame_pending;
          end
        end
        dps_pkg::MODE_FAST_START: begin
          resched = en_q && (fr_q == '0);
          if (fu_q < dps_pkg::MAX_FAST_POLL_USERS) begin
            fu_d = fu_q + 8'd1;
          end
          if (cnt == '0) begin
            cnt = dps_pkg::DEFAULT_FAST_POLLS;
          end
          if (cnt > dps_pkg::MAX_FAST_POLLS) begin
            cnt = dps_pkg::MAX_FAST_POLLS;
          end
          if (cnt > fr_q) begin
            fr_d = cnt;
          end
        end
        dps_pkg::MODE_FAST_STOP: begin
          // last user leaving reschedules even while disabled
          if (fu_q != '0 && fu_q < dps_pkg::MAX_FAST_POLL_USERS) begin
            fu_d = fu_q - 8'd1;
            if (fu_q == 8'd1) begin
              fr_d    = '0;
              resched = 1'b1;
            end
          end
        end
        dps_pkg::MODE_START: begin
          if (!en_q) begin
            en_d    = 1'b1;
            resched = 1'b1;
          end
        end
        dps_pkg::MODE_STOP: halt = 1'b1;
        dps_pkg::MODE_SEND: poll = 1'b1;
        dps_pkg::MODE_RECALC: resched = en_q;
        default: ;
      endcase
    end

    if (poll) begin
      if (!en_q || !item_i.parent_valid) begin
        halt         = 1'b1;
        res_o.status = 1'b1;
      end else begin
        res_o.send_poll = 1'b1;
        restart         = 1'b1;
      end
    end

    if (resched) begin
      per_d = calc_period(cfg_d, retx_d, fr_d != '0);
      if (run_q) begin
        if (per_d != per_q) begin
          // keep the original start unless that lands before now + min_period
          sa    = ts_q + {{(TW-PW){1'b0}}, per_d};
          sb    = ct_q + {{(TW-16){1'b0}}, cfg_d.min_period};
          sdiff = sa - sb;
          dl_d  = sdiff[TW-1] ? sb : sa;
        end
      end else begin
        ts_d  = ct_d;
        dl_d  = ct_d + {{(TW-PW){1'b0}}, per_d};
        run_d = 1'b1;
      end
    end

    if (restart) begin
      ts_d  = ct_d;
      dl_d  = ct_d + {{(TW-PW){1'b0}}, per_q};
      run_d = 1'b1;
    end

    if (halt) begin
      run_d             = 1'b0;
      cfg_d.attach_mode = 1'b0;
      retx_d            = 1'b0;
      to_d              = '0;
      fc_d              = '0;
      fr_d              = '0;
      fu_d              = '0;
      en_d              = 1'b0;
    end

    res_o.poll_period = per_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_period    <= PW'(240000);
      cfg_q.external_period   <= '0;
      cfg_q.attach_mode       <= 1'b0;
      cfg_q.attach_period     <= 16'd100;
      cfg_q.retx_period       <= 16'd1000;
      cfg_q.fast_period       <= 16'd188;
      cfg_q.min_period        <= 16'd10;
      cfg_q.max_retx_attempts <= 4'd5;
      en_q   <= 1'b0;
      retx_q <= 1'b0;
      run_q  <= 1'b0;
      fc_q   <= '0;
      to_q   <= '0;
      fr_q   <= '0;
      fu_q   <= '0;
      per_q  <= '0;
      ts_q   <= '0;
      ct_q   <= '0;
      dl_q   <= '0;
    end else begin
      cfg_q  <= cfg_d;
      en_q   <= en_d;
      retx_q <= retx_d;
      run_q  <= run_d;
      fc_q   <= fc_d;
      to_q   <= to_d;
      fr_q   <= fr_d;
      fu_q   <= fu_d;
      per_q  <= per_d;
      ts_q   <= ts_d;
      ct_q   <= ct_d;
      dl_q   <= dl_d;
    end
  end

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_i && !cfg_we_i && item_i.mode == dps_pkg::MODE_STOP)
    |=> (!en_q && !run_q && fu_q == '0 && fr_q == '0))
    else $error("stop left polling active");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_i && !cfg_we_i && !en_q && item_i.mode == dps_pkg::MODE_START)
    |=> (en_q && run_q))
    else $error("start did not arm the poll timer");

  a_send_xor_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.send_poll && res_o.status))
    else $error("poll sent and error flagged together");

  a_users_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fu_q <= dps_pkg::MAX_FAST_POLL_USERS && fr_q <= dps_pkg::MAX_FAST_POLLS)
    else $error("fast-poll counters out of range");

endmodule

// ----- sv/dps_outq.sv -----
// data poll scheduler result buffer: output register plus one skid entry
// depends on dps_pkg
module dps_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dps_pkg::res_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output dps_pkg::res_t data_o,
  input  logic          pop_ready_i
);

  logic          main_v_q, skid_v_q;
  dps_pkg::res_t main_q, skid_q;
  logic          pop;

  assign pop     = main_v_q && pop_ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          main_v_q <= push_i;
        end
      end else if (push_i) begin
        if (!main_v_q) begin
          main_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i && !main_v_q) begin
      main_q <= data_i;
    end
    if (push_i && main_v_q && !pop) begin
      skid_q <= data_i;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid word held with empty output register");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("word pushed into full result buffer");

endmodule

// ----- sv/data_poll_scheduler_top.sv -----
// data poll scheduler top level: channel wiring, config port, result buffer
// depends on dps_pkg, dps_if, dps_ctrl, dps_outq
//
// Usage:
//   in_i carries one word per event or millisecond tick (mode selects which);
//   every accepted word yields exactly one result word on out_o, in order.
//   cfg_i writes register index/data; write only while no result is pending.
//   cfg_i is always ready; in_i.ready is held low during a config write.
// Processing and throughput:
//   a word is processed in the cycle it is accepted; its result is registered
//   in the output register, or in the skid entry while that is held. One word
//   per cycle is sustained while in_i.ready is high: the dps_ctrl update (period
//   minimum, wrapping deadline compare) is one register-to-register stage.
// Stall:
//   a skid entry behind the output register lets one more word in while the
//   receiver holds ready low; in_i.ready drops once both entries are full.
// Reset:
//   counters, timer and time base clear, config registers take their reset
//   values, the result buffer empties; no clearing pass is needed.
module data_poll_scheduler_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  dps_in_if.sink  in_i,
  dps_res_if.source out_o,
  dps_cfg_if.sink cfg_i
);

  dps_pkg::item_t item;
  dps_pkg::res_t  res;
  dps_pkg::res_t  res_out;
  logic           q_ready;
  logic           in_acc;
  logic           cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign in_i.ready  = q_ready && !cfg_i.valid;
  assign in_acc      = in_i.valid && in_i.ready;

  assign item.mode            = in_i.mode;
  assign item.parent_valid    = in_i.parent_valid;
  assign item.tx_status       = in_i.tx_status;
  assign item.frame_pending   = in_i.frame_pending;
  assign item.fast_poll_count = in_i.fast_poll_count;

  dps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .item_i     (item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .res_o      (res)
  );

  dps_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .data_i      (res),
    .ready_o     (q_ready),
    .valid_o     (out_o.valid),
    .data_o      (res_out),
    .pop_ready_i (out_o.ready)
  );

  assign out_o.send_poll   = res_out.send_poll;
  assign out_o.poll_period = res_out.poll_period;
  assign out_o.detach      = res_out.detach;
  assign out_o.status      = res_out.status;

endmodule
